>>> hdl/sfd_pkg.sv
// sfd_pkg: shared constants and controller/datapath interface types
// for the serial frame deframer. No dependencies.
`default_nettype none

package sfd_pkg;

	// default store depth in payload bytes
	localparam int MAX_PAYLOAD_DEF = 64;

	// field widths
	localparam int BYTE_W = 8;
	localparam int NIB_W  = 4;
	localparam int LEN_W  = 7;

	// frame constants
	localparam logic [BYTE_W-1:0] PREAMBLE  = 8'hBC;
	localparam logic [BYTE_W-1:0] CSUM_SEED = 8'hFF;
	localparam logic [LEN_W-1:0]  LIMIT_RST = 7'd64;

	// commands from controller to datapath
	typedef struct packed {
		logic opf_load;
		logic len_lo_load;
		logic len_hi_load;
		logic data_store;
		logic csum_preamble;
		logic csum_seed;
		logic csum_xor;
		logic deliver_start;
		logic rd_issue;
		logic emit_data;
		logic emit_marker;
	} sfd_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic preamble;
		logic len_over;
		logic len_zero;
		logic data_done;
		logic csum_match;
		logic deliver_empty;
		logic idx_last;
		logic out_free;
	} sfd_stat_t;

endpackage

`default_nettype wire

>>> hdl/serial_frame_deframer.sv
// serial_frame_deframer: top level, preamble/length/XOR-checksum frame receiver.
// Depends on sfd_pkg, sfd_ctrl and sfd_dpath.
//
//   channel  signals                                   dir  meaning
//   input    in_valid, in_stall, rx_byte               in   one received byte
//   result   out_valid, out_stall, operation, flags,   out  one delivered byte
//            payload_length, data, data_valid, last         or empty marker
//   config   cfg_wen, cfg_wdata                        in   deliver_limit write
//
// A header, payload or checksum byte is taken whenever in_valid is high and no delivery runs.
// After a checksum match the input is stalled while the frame drains: each payload
// byte takes a store read, then a result register load; a marker takes only the load.
// The controller alternates a store read state and a result load state for each payload byte.
// Reset clears control state and sets deliver_limit to 64; the store is not cleared.
// A stalled result holds the drain, and the result register frees the input side.
`default_nettype none

module serial_frame_deframer #(
	parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [sfd_pkg::LEN_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [sfd_pkg::NIB_W-1:0]          operation,
	output logic [sfd_pkg::NIB_W-1:0]          flags,
	output logic [sfd_pkg::LEN_W-1:0]          payload_length,
	output logic [sfd_pkg::BYTE_W-1:0]         data,
	output logic                               data_valid,
	output logic                               last
);

	sfd_pkg::sfd_cmd_t  cmd;
	sfd_pkg::sfd_stat_t stat;

	// frame state machine
	sfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// registers, payload store and result register
	sfd_dpath #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.stat           (stat),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.operation      (operation),
		.flags          (flags),
		.payload_length (payload_length),
		.data           (data),
		.data_valid     (data_valid),
		.last           (last)
	);

endmodule

`default_nettype wire

>>> hdl/sfd_ctrl.sv
// sfd_ctrl: frame parsing and delivery state machine.
// Depends on sfd_pkg for the command and status structs.
`default_nettype none

module sfd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire sfd_pkg::sfd_stat_t stat,
	output sfd_pkg::sfd_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_OPF,
		ST_LEN_LO,
		ST_LEN_HI,
		ST_DATA,
		ST_CHECK,
		ST_RD,
		ST_EMIT,
		ST_MARK
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	// input is held off while a delivery drains
	assign in_stall = (state_q == ST_RD) || (state_q == ST_EMIT) || (state_q == ST_MARK);
	assign accept   = in_valid && !in_stall;

	// next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_HUNT: begin
				if (accept) begin
					if (stat.preamble) begin
						cmd.csum_preamble = 1'b1;
						state_nxt         = ST_OPF;
					end else begin
						cmd.csum_seed = 1'b1;
					end
				end
			end
			ST_OPF: begin
				if (accept) begin
					cmd.opf_load = 1'b1;
					cmd.csum_xor = 1'b1;
					state_nxt    = ST_LEN_LO;
				end
			end
			ST_LEN_LO: begin
				if (accept) begin
					cmd.len_lo_load = 1'b1;
					cmd.csum_xor    = 1'b1;
					state_nxt       = ST_LEN_HI;
				end
			end
			ST_LEN_HI: begin
				if (accept) begin
					cmd.len_hi_load = 1'b1;
					cmd.csum_xor    = 1'b1;
					if (stat.len_over) begin
						cmd.csum_seed = 1'b1;
						state_nxt     = ST_HUNT;
					end else if (stat.len_zero) begin
						state_nxt = ST_CHECK;
					end else begin
						state_nxt = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				if (accept) begin
					cmd.data_store = 1'b1;
					cmd.csum_xor   = 1'b1;
					if (stat.data_done) begin
						state_nxt = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (accept) begin
					cmd.csum_seed = 1'b1;
					if (stat.csum_match) begin
						cmd.deliver_start = 1'b1;
						state_nxt = stat.deliver_empty ? ST_MARK : ST_RD;
					end else begin
						state_nxt = ST_HUNT;
					end
				end
			end
			ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_nxt    = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_data = 1'b1;
					state_nxt     = stat.idx_last ? ST_HUNT : ST_RD;
				end
			end
			ST_MARK: begin
				if (stat.out_free) begin
					cmd.emit_marker = 1'b1;
					state_nxt       = ST_HUNT;
				end
			end
			default: begin
				state_nxt = ST_HUNT;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

>>> hdl/sfd_dpath.sv
// sfd_dpath: header registers, checksum, payload store and result register.
// Depends on sfd_pkg for constants and the command and status structs.
`default_nettype none

module sfd_dpath #(
	parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [sfd_pkg::LEN_W-1:0]     cfg_wdata,
	input  wire logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
	input  wire sfd_pkg::sfd_cmd_t             cmd,
	output sfd_pkg::sfd_stat_t                 stat,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic [sfd_pkg::NIB_W-1:0]          operation,
	output logic [sfd_pkg::NIB_W-1:0]          flags,
	output logic [sfd_pkg::LEN_W-1:0]          payload_length,
	output logic [sfd_pkg::BYTE_W-1:0]         data,
	output logic                               data_valid,
	output logic                               last
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int BW = sfd_pkg::BYTE_W;
	localparam int LW = sfd_pkg::LEN_W;
	localparam int NW = sfd_pkg::NIB_W;

	logic [LW-1:0] limit_q;
	logic [BW-1:0] csum_q;
	logic [BW-1:0] opf_q;
	logic [BW-1:0] len_lo_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] cnt_q;
	logic [LW-1:0] idx_q;
	logic [LW-1:0] n_q;
	logic [BW-1:0] rd_data_q;
	logic [BW-1:0] store_q [MAX_PAYLOAD];

	logic [2*BW-1:0] len_full;
	logic [LW:0]     cnt_inc;
	logic [LW-1:0]   n_next;
	logic            out_valid_q;

	assign len_full = {rx_byte, len_lo_q};
	assign cnt_inc  = {1'b0, cnt_q} + {{LW{1'b0}}, 1'b1};
	assign n_next   = (limit_q < len_q) ? limit_q : len_q;

	// status back to the controller
	always_comb begin
		stat.preamble      = (rx_byte == sfd_pkg::PREAMBLE);
		stat.len_over      = (len_full > (2*BW)'(MAX_PAYLOAD));
		stat.len_zero      = (len_full == '0);
		stat.data_done     = (cnt_inc >= {1'b0, len_q});
		stat.csum_match    = (rx_byte == csum_q);
		stat.deliver_empty = (n_next == '0);
		stat.idx_last      = ((idx_q + {{(LW-1){1'b0}}, 1'b1}) == n_q);
		stat.out_free      = !out_valid_q || !out_stall;
	end

	// delivery limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sfd_pkg::LIMIT_RST;
		end else if (cfg_wen) begin
			limit_q <= cfg_wdata;
		end
	end

	// running checksum, byte count and header fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum_q   <= sfd_pkg::CSUM_SEED;
			opf_q    <= '0;
			len_lo_q <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
		end else begin
			priority if (cmd.csum_seed) begin
				csum_q <= sfd_pkg::CSUM_SEED;
			end else if (cmd.csum_preamble) begin
				csum_q <= sfd_pkg::CSUM_SEED ^ sfd_pkg::PREAMBLE;
			end else if (cmd.csum_xor) begin
				csum_q <= csum_q ^ rx_byte;
			end
			if (cmd.opf_load) begin
				opf_q <= rx_byte;
			end
			if (cmd.len_lo_load) begin
				len_lo_q <= rx_byte;
			end
			if (cmd.len_hi_load) begin
				len_q <= len_full[LW-1:0];
			end
			if (cmd.len_hi_load || cmd.csum_seed || cmd.csum_preamble) begin
				cnt_q <= '0;
			end else if (cmd.data_store) begin
				cnt_q <= cnt_inc[LW-1:0];
			end
		end
	end

	// payload store, written during the data phase and read back one byte per read
	always_ff @(posedge clk) begin
		if (cmd.data_store) begin
			store_q[cnt_q[AW-1:0]] <= rx_byte;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= store_q[idx_q[AW-1:0]];
		end
	end

	// delivery count and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.deliver_start) begin
				n_q   <= n_next;
				idx_q <= '0;
			end else if (cmd.emit_data) begin
				idx_q <= idx_q + {{(LW-1){1'b0}}, 1'b1};
			end
		end
	end

	// result register, valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_data || cmd.emit_marker) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register, payload
	always_ff @(posedge clk) begin
		if (cmd.emit_data || cmd.emit_marker) begin
			operation      <= opf_q[NW-1:0];
			flags          <= opf_q[BW-1:NW];
			payload_length <= len_q;
			data           <= cmd.emit_data ? rd_data_q : '0;
			data_valid     <= cmd.emit_data;
			last           <= cmd.emit_marker || stat.idx_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
